// ===== sv/dbd_pkg.sv =====
// shared types, codes and constant dividers for the dxt block decoder
`default_nettype none

package dbd_pkg;

  localparam int NUM_PIX   = 16;
  localparam int PIX_IDX_W = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 2;

  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;
  localparam logic [1:0] FMT_DXT5 = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FORMAT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PUNCH  = 1'b1;

  localparam logic [PIX_IDX_W-1:0] LAST_PIX = 4'd15;

  // entry x channel (0 red, 1 green, 2 blue), plus per-entry alpha
  typedef struct packed {
    logic [3:0][2:0][7:0] rgb;
    logic [3:0][7:0]      a;
  } color_pal_t;

  typedef logic [NUM_PIX-1:0][7:0] pix_alpha_t;
  typedef logic [NUM_PIX-1:0][1:0] color_idx_t;

  // floor(x/3) for x < 768
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd683;
    return p[18:11];
  endfunction

  // floor(x/5) for x < 1280
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'd1639;
    return p[20:13];
  endfunction

  // floor(x/7) for x < 1792
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'd2341;
    return p[21:14];
  endfunction

endpackage

`default_nettype wire

// ===== sv/dbd_color_pal.sv =====
// color palette: 565 endpoint expansion and the interpolated entries
`default_nettype none

module dbd_color_pal (
  input  wire logic [63:0]         color_word,
  input  wire logic [1:0]          block_format,
  input  wire logic                punch_through,
  output dbd_pkg::color_pal_t      pal
);

  logic [15:0]     c0;
  logic [15:0]     c1;
  logic            three;
  logic [2:0][7:0] e0;
  logic [2:0][7:0] e1;
  logic [9:0]      s_a;
  logic [9:0]      s_b;
  logic [8:0]      s_h;

  always_comb begin
    c0 = color_word[15:0];
    c1 = color_word[31:16];
    three = (block_format == dbd_pkg::FMT_DXT1) && punch_through && (c0 <= c1);
    e0[0] = {c0[15:11], 3'b000};
    e0[1] = {c0[10:5], 2'b00};
    e0[2] = {c0[4:0], 3'b000};
    e1[0] = {c1[15:11], 3'b000};
    e1[1] = {c1[10:5], 2'b00};
    e1[2] = {c1[4:0], 3'b000};
    s_a = '0;
    s_b = '0;
    s_h = '0;
    pal = '0;
    for (int ch = 0; ch < 3; ch++) begin
      pal.rgb[0][ch] = e0[ch];
      pal.rgb[1][ch] = e1[ch];
      s_a = {1'b0, e0[ch], 1'b0} + {2'b00, e1[ch]};
      s_b = {2'b00, e0[ch]} + {1'b0, e1[ch], 1'b0};
      s_h = {1'b0, e0[ch]} + {1'b0, e1[ch]};
      if (three) begin
        pal.rgb[2][ch] = s_h[8:1];
        pal.rgb[3][ch] = 8'd0;
      end else begin
        pal.rgb[2][ch] = dbd_pkg::div3(s_a);
        pal.rgb[3][ch] = dbd_pkg::div3(s_b);
      end
    end
    pal.a[0] = 8'd255;
    pal.a[1] = 8'd255;
    pal.a[2] = 8'd255;
    pal.a[3] = three ? 8'd0 : 8'd255;
  end

endmodule

`default_nettype wire

// ===== sv/dbd_alpha_pal.sv =====
// per-pixel alpha for explicit and interpolated alpha blocks
`default_nettype none

module dbd_alpha_pal (
  input  wire logic [63:0]        alpha_word,
  input  wire logic [1:0]         block_format,
  output dbd_pkg::pix_alpha_t     pix_alpha
);

  logic [7:0]      a0;
  logic [7:0]      a1;
  logic [7:0][7:0] apal;
  logic [3:0]      nib;

  always_comb begin
    a0 = alpha_word[7:0];
    a1 = alpha_word[15:8];
    apal = '0;
    apal[0] = a0;
    apal[1] = a1;
    if (a0 > a1) begin
      for (int k = 1; k <= 6; k++) begin
        apal[k+1] = dbd_pkg::div7(11'(7 - k) * {3'b000, a0} + 11'(k) * {3'b000, a1});
      end
    end else begin
      for (int k = 1; k <= 4; k++) begin
        apal[k+1] = dbd_pkg::div5(11'(5 - k) * {3'b000, a0} + 11'(k) * {3'b000, a1});
      end
      apal[6] = 8'd0;
      apal[7] = 8'd255;
    end
    nib = '0;
    for (int i = 0; i < dbd_pkg::NUM_PIX; i++) begin
      nib = alpha_word[4*i +: 4];
      if (block_format == dbd_pkg::FMT_DXT3) begin
        pix_alpha[i] = {nib, nib};
      end else begin
        pix_alpha[i] = apal[alpha_word[16 + 3*i +: 3]];
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/dxt_block_decoder_top.sv =====
// top level of the dxt1/dxt3/dxt5 4x4 block decoder
//
// in channel: one compressed block per transaction, color word in
// in_tdata[63:0] and alpha word in in_tdata[127:64].
// out channel: sixteen pixel transactions per block in raster order,
// out_tlast set on the sixteenth.
// cfg port: index 0 block format, index 1 punch-through enable; write
// only while no block is in flight.
// datapath: input register, palette register (color palette, per-pixel
// alpha, color indices), pixel select into the output register.
// order: a block passes the input register and the palette register
// before pixel 0 shows on out_tvalid from the output register; the rest
// follow one per cycle while out_tready is high. throughput is set by
// the single output port emitting one pixel a cycle; the next block is
// taken and its palette built while the current one is still streaming out.
// reset: drops all valid flags, format resets to dxt1 and punch-through
// to off.
// stall: a low out_tready holds the output register; the palette and
// input registers then fill and in_tready goes low.
`default_nettype none

module dxt_block_decoder_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  input  wire logic [127:0] in_tdata,   // color_word, alpha_word
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  output      logic [39:0]  out_tdata,  // red, green, blue, alpha, pixel_index, 4 zero bits
  output      logic         out_tlast,  // last_pixel
  input  wire logic         cfg_we,
  input  wire logic [dbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dbd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [1:0]  block_format_r;
  logic        punch_through_r;

  logic        in_v_r;
  logic        in_v_nxt;
  logic [63:0] color_word_r;
  logic [63:0] alpha_word_r;

  logic                  pal_v_r;
  logic                  pal_v_nxt;
  logic [3:0]            cnt_r;
  logic [3:0]            cnt_nxt;
  dbd_pkg::color_pal_t   cpal_r;
  dbd_pkg::pix_alpha_t   palpha_r;
  dbd_pkg::color_idx_t   ci_r;
  logic                  dxt1_r;

  logic        out_v_r;
  logic        out_v_nxt;
  logic [7:0]  red_r;
  logic [7:0]  green_r;
  logic [7:0]  blue_r;
  logic [7:0]  alpha_r;
  logic [3:0]  pix_idx_r;
  logic        last_r;

  dbd_pkg::color_pal_t cpal;
  dbd_pkg::pix_alpha_t palpha;

  logic        in_take;
  logic        emit;
  logic        pal_free;
  logic        pal_load;
  logic [1:0]  ci;

  dbd_color_pal u_color_pal (
    .color_word    (color_word_r),
    .block_format  (block_format_r),
    .punch_through (punch_through_r),
    .pal           (cpal)
  );

  dbd_alpha_pal u_alpha_pal (
    .alpha_word   (alpha_word_r),
    .block_format (block_format_r),
    .pix_alpha    (palpha)
  );

  always_comb begin
    emit      = pal_v_r && (!out_v_r || out_tready);
    pal_free  = !pal_v_r || (emit && (cnt_r == dbd_pkg::LAST_PIX));
    in_tready = !in_v_r || pal_free;
    in_take   = in_tvalid && in_tready;
    pal_load  = in_v_r && pal_free;

    in_v_nxt = in_v_r;
    if (pal_load) begin
      in_v_nxt = 1'b0;
    end
    if (in_take) begin
      in_v_nxt = 1'b1;
    end

    pal_v_nxt = pal_v_r;
    cnt_nxt   = cnt_r;
    if (emit) begin
      cnt_nxt = cnt_r + 4'd1;
    end
    if (pal_free) begin
      pal_v_nxt = pal_load;
      cnt_nxt   = '0;
    end

    out_v_nxt = out_v_r;
    if (out_tready) begin
      out_v_nxt = 1'b0;
    end
    if (emit) begin
      out_v_nxt = 1'b1;
    end

    ci = ci_r[cnt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_format_r  <= dbd_pkg::FMT_DXT1;
      punch_through_r <= 1'b0;
      in_v_r          <= 1'b0;
      pal_v_r         <= 1'b0;
      cnt_r           <= '0;
      out_v_r         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          dbd_pkg::CFG_IDX_FORMAT: block_format_r  <= cfg_wdata;
          dbd_pkg::CFG_IDX_PUNCH:  punch_through_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      in_v_r  <= in_v_nxt;
      pal_v_r <= pal_v_nxt;
      cnt_r   <= cnt_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      color_word_r <= in_tdata[63:0];
      alpha_word_r <= in_tdata[127:64];
    end
    if (pal_load) begin
      cpal_r   <= cpal;
      palpha_r <= palpha;
      ci_r     <= color_word_r[63:32];
      dxt1_r   <= (block_format_r == dbd_pkg::FMT_DXT1);
    end
    if (emit) begin
      red_r     <= cpal_r.rgb[ci][0];
      green_r   <= cpal_r.rgb[ci][1];
      blue_r    <= cpal_r.rgb[ci][2];
      alpha_r   <= dxt1_r ? cpal_r.a[ci] : palpha_r[cnt_r];
      pix_idx_r <= cnt_r;
      last_r    <= (cnt_r == dbd_pkg::LAST_PIX);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'b0000, pix_idx_r, alpha_r, blue_r, green_r, red_r};
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

// ===== sv/dbd_checker.sv =====
// port-level checks for the dxt block decoder, bound to the top level
`default_nettype none

module dbd_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [39:0]  out_tdata,
  input wire logic         out_tlast
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output transaction changed");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[35:32] == 4'd15)) && (out_tdata[39:36] == 4'd0))
    else $error("tlast or padding does not match pixel index");

  a_pixel_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && (out_tdata[35:32] == $past(out_tdata[35:32]) + 4'd1))
    else $error("pixel stream broke inside a block");

endmodule

bind dxt_block_decoder_top dbd_checker u_dbd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
